>>> sv/tsq_pkg.sv
// Shared types and constants for the timed sleep/wakeup queue.
package tsq_pkg;

    localparam int ID_W   = 6;
    localparam int TICK_W = 63;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_WAKE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   thread_id;
        logic [TICK_W-1:0] tick;
    } t_in;

    typedef struct packed {
        logic              woken_valid;
        logic [ID_W-1:0]   woken_id;
        logic [TICK_W-1:0] next_wakeup;
        logic              rejected;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0]   thread_id;
        logic [TICK_W-1:0] wakeup;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic load;
        logic scan_init;
        logic sleep_commit;
        logic scan_step;
        logic scan_finish;
        logic emit_push;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic out_free;
        logic scan_done;
        logic emit_last;
    } t_sts;

endpackage

>>> sv/tsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tsq_ctrl.sv
// Sequencing state machine for the timed sleep/wakeup queue.
module tsq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tsq_pkg::t_sts i_sts,
    output tsq_pkg::t_cmd o_cmd
);
    import tsq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SLEEP = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EMRD  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_WAKE) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_SLEEP;
                end
            end
            S_SLEEP: begin
                if (i_sts.out_free) begin
                    o_cmd.sleep_commit = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = S_EMRD;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EMRD: begin
                // Wait state for the woken-id memory read to land.
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_push = 1'b1;
                    n_state         = i_sts.emit_last ? S_IDLE : S_EMRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> sv/tsq_dp.sv
// Datapath of the timed sleep/wakeup queue: slot memory, scan, and output word.
module tsq_dp #(
    parameter int SLEEP_SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tsq_pkg::t_in             i_in_data,
    input  logic                     i_cfg_valid,
    input  logic [tsq_pkg::ID_W-1:0] i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output tsq_pkg::t_out            o_out_data,
    input  tsq_pkg::t_cmd            i_cmd,
    output tsq_pkg::t_sts            o_sts
);
    import tsq_pkg::*;

    localparam int CNT_W = $clog2(SLEEP_SLOTS + 1);
    localparam int AW    = (SLEEP_SLOTS > 1) ? $clog2(SLEEP_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLEEP_SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // Control state.
    logic [ID_W-1:0]   r_idle_id, n_idle_id;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TICK_W-1:0] r_earliest, n_earliest;
    logic              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;

    // Working registers.
    logic              r_op, n_op;
    logic [ID_W-1:0]   r_tid, n_tid;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_keep, n_keep;
    logic [CNT_W-1:0]  r_nw, n_nw;
    logic [CNT_W-1:0]  r_em_idx, n_em_idx;
    logic [TICK_W-1:0] r_min, n_min;
    t_out              r_out, n_out;

    logic              slot_we;
    logic [AW-1:0]     slot_waddr;
    t_slot             slot_wdata;
    logic [SLOT_W-1:0] slot_rdata;
    t_slot             entry;
    logic              woken_we;
    logic [ID_W-1:0]   woken_rdata;

    logic append;
    logic rd_go;
    logic due;
    logic out_free;
    logic out_load;

    assign entry    = t_slot'(slot_rdata);
    assign append   = (r_tid != r_idle_id) && (r_count < SLOTS_C);
    assign rd_go    = (r_rd_idx < r_count);
    assign due      = (entry.wakeup <= r_tick);
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.sleep_commit || i_cmd.emit_push;

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_keep[AW-1:0];
        slot_wdata = entry;
        woken_we   = 1'b0;
        if (i_cmd.sleep_commit) begin
            slot_we    = append;
            slot_waddr = r_count[AW-1:0];
            slot_wdata = '{thread_id: r_tid, wakeup: r_tick};
        end else if (i_cmd.scan_step && r_pend) begin
            slot_we  = !due;
            woken_we = due;
        end
    end

    always_comb begin
        n_idle_id   = r_idle_id;
        n_count     = r_count;
        n_earliest  = r_earliest;
        n_pend      = r_pend;
        n_op        = r_op;
        n_tid       = r_tid;
        n_tick      = r_tick;
        n_rd_idx    = r_rd_idx;
        n_keep      = r_keep;
        n_nw        = r_nw;
        n_em_idx    = r_em_idx;
        n_min       = r_min;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cfg_valid) begin
            n_idle_id = i_cfg_data;
        end
        if (i_cmd.load) begin
            n_op   = i_in_data.operation;
            n_tid  = i_in_data.thread_id;
            n_tick = i_in_data.tick;
        end
        if (i_cmd.scan_init) begin
            n_rd_idx = '0;
            n_keep   = '0;
            n_nw     = '0;
            n_em_idx = '0;
            n_min    = TICK_MAX;
            n_pend   = 1'b0;
        end
        if (i_cmd.sleep_commit) begin
            if (append) begin
                n_count = r_count + ONE_C;
                if (r_tick < r_earliest) begin
                    n_earliest = r_tick;
                end
            end
            n_out.woken_valid = 1'b0;
            n_out.woken_id    = '0;
            n_out.next_wakeup = n_earliest;
            n_out.rejected    = (r_tid != r_idle_id) && !append;
            n_out.last        = 1'b1;
        end
        if (i_cmd.scan_step) begin
            // Reads run one entry ahead of the compare and compaction.
            n_pend = rd_go;
            if (rd_go) begin
                n_rd_idx = r_rd_idx + ONE_C;
            end
            if (r_pend) begin
                if (due) begin
                    n_nw = r_nw + ONE_C;
                end else begin
                    n_keep = r_keep + ONE_C;
                    if (entry.wakeup < r_min) begin
                        n_min = entry.wakeup;
                    end
                end
            end
        end
        if (i_cmd.scan_finish) begin
            n_count    = r_keep;
            n_earliest = r_min;
        end
        if (i_cmd.emit_push) begin
            n_em_idx          = r_em_idx + ONE_C;
            n_out.woken_valid = (r_nw != '0);
            n_out.woken_id    = (r_nw != '0) ? woken_rdata : '0;
            n_out.next_wakeup = r_earliest;
            n_out.rejected    = 1'b0;
            n_out.last        = ((r_em_idx + ONE_C) >= r_nw);
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_id   <= '0;
            r_count     <= '0;
            r_earliest  <= TICK_MAX;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idle_id   <= n_idle_id;
            r_count     <= n_count;
            r_earliest  <= n_earliest;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_tid    <= n_tid;
        r_tick   <= n_tick;
        r_rd_idx <= n_rd_idx;
        r_keep   <= n_keep;
        r_nw     <= n_nw;
        r_em_idx <= n_em_idx;
        r_min    <= n_min;
        r_out    <= n_out;
    end

    tsq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLEEP_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (SLOT_W'(slot_wdata)),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (slot_rdata)
    );

    tsq_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLEEP_SLOTS)
    ) u_woken_ram (
        .i_clk   (i_clk),
        .i_we    (woken_we),
        .i_waddr (r_nw[AW-1:0]),
        .i_wdata (entry.thread_id),
        .i_raddr (r_em_idx[AW-1:0]),
        .o_rdata (woken_rdata)
    );

    assign o_sts.op        = r_op;
    assign o_sts.out_free  = out_free;
    assign o_sts.scan_done = !r_pend && !rd_go;
    assign o_sts.emit_last = ((r_em_idx + ONE_C) >= r_nw);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/timed_sleep_wakeup_queue.sv
// Timed sleep/wakeup queue: holds up to SLEEP_SLOTS sleeping thread ids in
// insertion order with their wake-up ticks and reports the earliest pending
// tick (all ones when empty). A sleep word yields a single result word; sleeps
// from the idle thread are dropped, and a full queue returns rejected. For a
// wake word the slot memory is scanned and compacted one entry per cycle, and
// each woken id is then read back from the woken-id memory through a read-wait
// state before its result word; a wake with none due gives one word without an
// id. Results carry the recomputed earliest tick, and the last word of each
// item is flagged. A new input word is taken while the final result still sits
// in the output register.
module timed_sleep_wakeup_queue #(
    parameter int SLEEP_SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  tsq_pkg::t_in             i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output tsq_pkg::t_out            o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [tsq_pkg::ID_W-1:0] i_cfg_data
);
    import tsq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsq_dp #(
        .SLEEP_SLOTS (SLEEP_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign o_cfg_ready = 1'b1;

endmodule

>>> verif/tb_timed_sleep_wakeup_queue.sv
// Self-checking testbench for the timed sleep/wakeup queue.
`timescale 1ns / 100ps

module tb_timed_sleep_wakeup_queue;
    import tsq_pkg::*;

    localparam int SLEEP_SLOTS  = 16;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 76;

    // Tracks the sleepers and the words the block owes us.
    class sleep_queue_scoreboard;
        t_slot           sleepers[$];
        t_out            owed_words[$];
        logic [ID_W-1:0] idle_id;
        int              mismatches;
        int              words_seen;

        function new();
            idle_id    = '0;
            mismatches = 0;
            words_seen = 0;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function logic [TICK_W-1:0] earliest();
            logic [TICK_W-1:0] m;
            m = TICK_MAX;
            foreach (sleepers[i])
                if (sleepers[i].wakeup < m)
                    m = sleepers[i].wakeup;
            return m;
        endfunction

        function void note_request(t_in w);
            t_slot           kept[$];
            logic [ID_W-1:0] woken[$];
            t_slot           s;
            t_out            r;
            logic            rej;

            rej = 1'b0;
            r   = '0;
            if (w.operation == OP_SLEEP) begin
                if (w.thread_id != idle_id) begin
                    if (sleepers.size() >= SLEEP_SLOTS) begin
                        rej = 1'b1;
                    end else begin
                        s.thread_id = w.thread_id;
                        s.wakeup    = w.tick;
                        sleepers.push_back(s);
                    end
                end
                r.next_wakeup = earliest();
                r.rejected    = rej;
                r.last        = 1'b1;
                owed_words.push_back(r);
            end else begin
                foreach (sleepers[i]) begin
                    if (sleepers[i].wakeup <= w.tick)
                        woken.push_back(sleepers[i].thread_id);
                    else
                        kept.push_back(sleepers[i]);
                end
                sleepers      = kept;
                r.next_wakeup = earliest();
                if (woken.size() == 0) begin
                    r.last = 1'b1;
                    owed_words.push_back(r);
                end else begin
                    foreach (woken[i]) begin
                        r.woken_valid = 1'b1;
                        r.woken_id    = woken[i];
                        r.last        = (i == woken.size() - 1);
                        owed_words.push_back(r);
                    end
                end
            end
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] word %0d: %s", $time, words_seen, what);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [63:0] got,
                           input logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        task check_word(input t_out got);
            t_out want;
            words_seen++;
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = owed_words.pop_front();
            compare_field("woken_valid", 64'(got.woken_valid), 64'(want.woken_valid));
            compare_field("woken_id", 64'(got.woken_id), 64'(want.woken_id));
            compare_field("next_wakeup", 64'(got.next_wakeup), 64'(want.next_wakeup));
            compare_field("rejected", 64'(got.rejected), 64'(want.rejected));
            compare_field("last", 64'(got.last), 64'(want.last));
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in             i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out            o_out_data;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [ID_W-1:0] i_cfg_data;

    sleep_queue_scoreboard book;
    logic                  hold_off_req;
    logic                  steady_sender;
    int                    burst_left;

    timed_sleep_wakeup_queue #(
        .SLEEP_SLOTS(SLEEP_SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        hold_off_req  = 1'b0;
        steady_sender = 1'b0;
        burst_left    = 1;
        book          = new();
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                book.note_request(i_in_data);
            if (o_out_valid && i_out_ready)
                book.check_word(o_out_data);
        end
    end

    initial begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver mixes free-running stretches, random and patterned stalls,
    // and the long hold-off that backs the block up into its input.
    initial begin : receiver
        int n;
        int k;
        int kind;
        logic [7:0] pat;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                kind = $urandom_range(0, 3);
                n    = $urandom_range(4, 24);
                pat  = 8'($urandom()) | 8'h01;
                case (kind)
                    0: begin
                        i_out_ready <= 1'b1;
                        repeat (n) @(posedge i_clk);
                    end
                    1: begin
                        repeat (n) begin
                            i_out_ready <= ($urandom_range(0, 3) != 0);
                            @(posedge i_clk);
                        end
                    end
                    2: begin
                        for (k = 0; k < n; k++) begin
                            i_out_ready <= pat[k % 8];
                            @(posedge i_clk);
                        end
                    end
                    default: begin
                        i_out_ready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    function automatic logic [TICK_W-1:0] random_tick();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[TICK_W-1:0];
    endfunction

    function automatic t_in make_word(input logic op, input logic [ID_W-1:0] id,
                                      input logic [TICK_W-1:0] tick);
        t_in w;
        w.operation = op;
        w.thread_id = id;
        w.tick      = tick;
        return w;
    endfunction

    task automatic send_item(input t_in w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left <= 0) begin
            if (steady_sender) begin
                burst_left = 1000;
            end else begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                         : $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (book.pending() != 0);
    endtask

    task automatic write_idle_id(input logic [ID_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        book.idle_id = v;
    endtask

    task automatic random_phase(input int count, input int sleep_pct);
        t_in               w;
        logic [TICK_W-1:0] now;
        int                r;
        case ($urandom_range(0, 2))
            0:       now = TICK_W'($urandom_range(0, 100));
            1:       now = random_tick();
            default: now = TICK_MAX - TICK_W'($urandom_range(0, 2000));
        endcase
        repeat (count) begin
            w.thread_id = ID_W'($urandom_range(0, 63));
            if ($urandom_range(0, 9) == 0)
                w.thread_id = book.idle_id;
            if ($urandom_range(0, 99) < sleep_pct) begin
                w.operation = OP_SLEEP;
                r = $urandom_range(0, 19);
                if (r == 0)
                    w.tick = random_tick();
                else if (r == 1)
                    w.tick = TICK_MAX;
                else if (r == 2)
                    w.tick = '0;
                else
                    w.tick = now + TICK_W'($urandom_range(0, 60));
            end else begin
                w.operation = OP_WAKE;
                r = $urandom_range(0, 29);
                if (r == 0)
                    w.tick = random_tick();
                else if (r == 1)
                    w.tick = TICK_MAX;
                else if (r == 2)
                    w.tick = '0;
                else begin
                    now    = now + TICK_W'($urandom_range(0, 25));
                    w.tick = now;
                end
            end
            send_item(w);
        end
    endtask

    initial begin : stimulus
        int              ph;
        int              k;
        int              idle_choice[PHASES];
        int              sleep_share[PHASES];
        logic [ID_W-1:0] idle_val;

        idle_choice = '{63, -1, 0, -1, 1, 62};
        sleep_share = '{55, 85, 45, 70, 90, 60};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_idle_id('0);
        // Empty queue wake, idle sleep, extreme ids and ticks, a duplicate id.
        send_item(make_word(OP_WAKE, 6'd0, '0));
        send_item(make_word(OP_SLEEP, 6'd0, TICK_W'(5)));
        send_item(make_word(OP_SLEEP, 6'd63, '0));
        send_item(make_word(OP_SLEEP, 6'd1, TICK_MAX));
        send_item(make_word(OP_SLEEP, 6'd63, TICK_W'(10)));
        send_item(make_word(OP_WAKE, 6'd63, '0));
        // Fill the queue to the brim, then overflow it once.
        for (k = 2; k < 16; k++)
            send_item(make_word(OP_SLEEP, ID_W'(k), TICK_W'(1000 - 37 * k)));
        send_item(make_word(OP_SLEEP, 6'd20, TICK_W'(3)));
        // Everything but the all-ones sleeper is due, then that one too.
        send_item(make_word(OP_WAKE, 6'd0, TICK_MAX - TICK_W'(1)));
        send_item(make_word(OP_WAKE, 6'd0, TICK_MAX));
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            idle_val = (idle_choice[ph] < 0) ? ID_W'($urandom_range(0, 63))
                                             : ID_W'(idle_choice[ph]);
            write_idle_id(idle_val);
            steady_sender = (ph == 1 || ph == 4);
            hold_off_req  = steady_sender;
            burst_left    = 1;
            random_phase(PHASE_ITEMS, sleep_share[ph]);
            drain();
            steady_sender = 1'b0;
        end

        // Leave room for any stray word after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
